// ----- rtl/sbal_pkg.sv -----
`default_nettype none
// ============================================================================
// sbal_pkg - shared types and constants of the band autorange level block
// Band map, reset values, register codes and the structures passed between
// the bin front end, the frame-end settle sequencer and its divider.
// ============================================================================
package sbal_pkg;

    localparam int BAND_COUNT = 6;
    localparam int BAND_W     = 3;
    localparam int NUM_BINS   = 256;
    localparam int PEAK_W     = 31;
    localparam int TRK_W      = 32;
    localparam int DS_W       = 16;
    localparam int Q16_W      = 17;
    localparam int Q16_FRAC   = 16;
    localparam int LEVEL_W    = 8;
    localparam int Q5_W       = 28;

    localparam logic [BAND_W-1:0] LAST_BAND = 3'd5;

    // Band edges (last bin of each band); bins below BIN_FIRST are ignored.
    localparam logic [7:0] BIN_FIRST  = 8'd2;
    localparam logic [7:0] BAND0_LAST = 8'd3;
    localparam logic [7:0] BAND1_LAST = 8'd7;
    localparam logic [7:0] BAND2_LAST = 8'd18;
    localparam logic [7:0] BAND3_LAST = 8'd48;
    localparam logic [7:0] BAND4_LAST = 8'd128;

    localparam logic [4:0]  SPAN_UNITS = 5'd20;
    // floor(x / 5) = (x * RECIP5) >> 34 for any 32-bit x.
    localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;
    localparam int          RECIP5_SH  = 34;

    localparam logic [DS_W-1:0]  DECAY_RESET = 16'd100;
    localparam logic [Q16_W-1:0] FALL_RESET  = 17'd3277;
    localparam logic [Q16_W-1:0] CUT_RESET   = 17'd0;

    typedef enum logic [1:0] {
        CFG_DECAY_START  = 2'd0,
        CFG_FALL_LIMIT   = 2'd1,
        CFG_LEVEL_CUTOFF = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [DS_W-1:0]  decay_start;
        logic [Q16_W-1:0] fall_limit;
        logic [Q16_W-1:0] level_cutoff;
    } t_cfg;

    typedef struct packed {
        logic [TRK_W-1:0] floor_trk;
        logic [TRK_W-1:0] ceil_trk;
        logic [TRK_W-1:0] floor_step;
        logic [TRK_W-1:0] ceil_step;
    } t_track;

    localparam t_track TRACK_RESET = '{
        floor_trk:  32'd0,
        ceil_trk:   32'd0,
        floor_step: {16'd0, DECAY_RESET},
        ceil_step:  {16'd0, DECAY_RESET}
    };

    typedef struct packed {
        logic              start;
        logic [BAND_W-1:0] band;
        logic [PEAK_W-1:0] peak;
    } t_settle_req;

    typedef struct packed {
        logic               strobe;
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_result;

    // Returns {hit, band}; hit is low for ignored bins.
    function automatic logic [BAND_W:0] band_of(input logic [7:0] bin);
        logic              hit;
        logic [BAND_W-1:0] band;
        hit = (bin >= BIN_FIRST) && (int'(bin) < NUM_BINS);
        if (bin <= BAND0_LAST) begin
            band = 3'd0;
        end else if (bin <= BAND1_LAST) begin
            band = 3'd1;
        end else if (bin <= BAND2_LAST) begin
            band = 3'd2;
        end else if (bin <= BAND3_LAST) begin
            band = 3'd3;
        end else if (bin <= BAND4_LAST) begin
            band = 3'd4;
        end else begin
            band = 3'd5;
        end
        return {hit, band};
    endfunction

    // s * 21 / 20 = s + floor(floor(s / 4) / 5), saturated to 32 bits.
    function automatic logic [TRK_W-1:0] grow_sat(input logic [TRK_W-1:0] s,
                                                  input logic [Q5_W-1:0] q5);
        logic [TRK_W:0] sum;
        sum = {1'b0, s} + (TRK_W+1)'(q5);
        return sum[TRK_W] ? '1 : sum[TRK_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sbal_divider.sv -----
`default_nettype none
// ============================================================================
// sbal_divider - restoring divider for the band scale
// Produces floor((dividend << FRACTION_BITS) / divisor), one quotient bit a
// cycle, for a dividend no larger than the divisor.
// ============================================================================
module sbal_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_dividend,
    input  logic [31:0]              i_divisor,
    output logic                     o_done,
    output logic [FRACTION_BITS:0]   o_quotient
);

    localparam int STEPS = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [32:0]      r_rem;
    logic [31:0]      r_div;
    logic [FRACTION_BITS:0] r_q;

    logic        ge;
    logic [32:0] rem_next;

    always_comb begin
        ge       = r_rem >= {1'b0, r_div};
        rem_next = ge ? (r_rem - {1'b0, r_div}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_dividend};
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // The remainder stays below the divisor, so the shift fits.
                r_rem <= {rem_next[31:0], 1'b0};
                r_q   <= {r_q[FRACTION_BITS-1:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    // The quotient never exceeds one whole.
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_quotient[FRACTION_BITS] == 1'b0 ||
                    o_quotient[FRACTION_BITS-1:0] == '0))
        else $error("divider quotient above one");

endmodule
`default_nettype wire

// ----- rtl/sbal_settle.sv -----
`default_nettype none
// ============================================================================
// sbal_settle - frame-end sequencer for one band at a time
// Reads the band's tracker entry, closes and snaps floor and ceiling, scales
// the peak through the divider, applies fall limit and cutoff, writes back.
// ============================================================================
module sbal_settle #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sbal_pkg::t_settle_req i_req,
    input  sbal_pkg::t_cfg        i_cfg,
    output sbal_pkg::t_result     o_result
);

    localparam int FRAC_W   = FRACTION_BITS + 1;
    localparam int EXT_W    = sbal_pkg::Q16_W + FRACTION_BITS;
    localparam int TRK_BITS = $bits(sbal_pkg::t_track);
    localparam int MEM_W    = TRK_BITS + FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_FLOOR, S_FGROW, S_CEIL, S_CGROW,
        S_SNAP, S_SPAN, S_DIV, S_FALL
    } t_state;

    t_state                          r_state;
    logic [sbal_pkg::BAND_W-1:0]     r_band;
    logic [sbal_pkg::PEAK_W-1:0]     r_peak;
    logic [31:0]                     r_lo;
    logic [31:0]                     r_hi;
    logic [31:0]                     r_fs;
    logic [31:0]                     r_cs;
    logic [FRAC_W-1:0]               r_prev;
    logic [FRAC_W-1:0]               r_lvl;
    logic [sbal_pkg::Q5_W-1:0]       r_q5;
    sbal_pkg::t_result               r_result;

    // Tracker memory: one word per band, {previous level, trackers}.
    logic [MEM_W-1:0]                r_mem [sbal_pkg::BAND_COUNT];
    logic [sbal_pkg::BAND_COUNT-1:0] r_mem_vld;
    logic [MEM_W-1:0]                r_rd_word;
    logic                            r_rd_vld;

    sbal_pkg::t_track  trk_rd;
    sbal_pkg::t_track  trk_wr;
    logic [FRAC_W-1:0] prev_rd;
    logic              mem_wr_en;

    logic [EXT_W-1:0]  fall_ext;
    logic [EXT_W-1:0]  cut_ext;
    logic [FRAC_W-1:0] fall_frac;
    logic [FRAC_W-1:0] cut_frac;
    logic [FRAC_W:0]   lvl_sum;
    logic [FRAC_W-1:0] lvl_lim;
    logic [FRAC_W-1:0] lvl_final;
    logic [FRAC_W+7:0] scaled;

    logic [29:0]       mul_in;
    logic [61:0]       prod;
    logic [32:0]       fsum;
    logic              floor_close;
    logic              ceil_close;
    logic [31:0]       span;
    logic [20:0]       min_span;
    logic              span_ok;

    logic              div_start;
    logic [31:0]       div_dividend;
    logic              div_done;
    logic [FRAC_W-1:0] div_q;

    always_comb begin
        trk_rd  = r_rd_vld ? sbal_pkg::t_track'(r_rd_word[TRK_BITS-1:0])
                           : sbal_pkg::TRACK_RESET;
        prev_rd = r_rd_vld ? r_rd_word[MEM_W-1:TRK_BITS] : '0;

        trk_wr  = '{floor_trk: r_lo, ceil_trk: r_hi, floor_step: r_fs, ceil_step: r_cs};
        mem_wr_en = (r_state == S_FALL);

        // Q1.16 registers moved to the working fraction width.
        fall_ext  = EXT_W'(i_cfg.fall_limit) << FRACTION_BITS;
        cut_ext   = EXT_W'(i_cfg.level_cutoff) << FRACTION_BITS;
        fall_frac = FRAC_W'(fall_ext >> sbal_pkg::Q16_FRAC);
        cut_frac  = FRAC_W'(cut_ext >> sbal_pkg::Q16_FRAC);

        lvl_sum   = {1'b0, r_lvl} + {1'b0, fall_frac};
        lvl_lim   = (lvl_sum < {1'b0, r_prev}) ? (r_prev - fall_frac) : r_lvl;
        lvl_final = (lvl_lim < cut_frac) ? '0 : lvl_lim;
        scaled    = {lvl_final, 8'd0} - (FRAC_W+8)'(lvl_final);

        // One shared multiplier serves both step growths.
        mul_in = (r_state == S_CEIL) ? r_cs[31:2] : r_fs[31:2];
        prod   = mul_in * sbal_pkg::RECIP5;

        fsum        = {1'b0, r_lo} + {1'b0, r_fs};
        floor_close = (r_fs != '0) && !fsum[32] && ({1'b0, r_hi} > {r_lo, 1'b0});
        ceil_close  = (r_cs != '0) && (r_cs <= r_hi) && ((r_hi - r_cs) > r_lo);

        span     = r_hi - r_lo;
        min_span = i_cfg.decay_start * sbal_pkg::SPAN_UNITS;
        span_ok  = span > 32'(min_span);

        div_start    = (r_state == S_SPAN) && span_ok;
        div_dividend = 32'(r_peak) - r_lo;
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[i_req.band];
        if (mem_wr_en) begin
            r_mem[r_band] <= {lvl_final, trk_wr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_mem_vld[i_req.band];
            if (mem_wr_en) begin
                r_mem_vld[r_band] <= 1'b1;
            end
        end
    end

    sbal_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (span),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_result.strobe <= 1'b0;
        end else begin
            r_result.strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_band  <= i_req.band;
                        r_peak  <= i_req.peak;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_lo    <= trk_rd.floor_trk;
                    r_hi    <= trk_rd.ceil_trk;
                    r_fs    <= trk_rd.floor_step;
                    r_cs    <= trk_rd.ceil_step;
                    r_prev  <= prev_rd;
                    r_state <= S_FLOOR;
                end
                S_FLOOR: begin
                    if (floor_close) begin
                        r_lo    <= fsum[31:0];
                        r_q5    <= prod[61:sbal_pkg::RECIP5_SH];
                        r_state <= S_FGROW;
                    end else begin
                        r_state <= S_CEIL;
                    end
                end
                S_FGROW: begin
                    r_fs    <= sbal_pkg::grow_sat(r_fs, r_q5);
                    r_state <= S_CEIL;
                end
                S_CEIL: begin
                    if (ceil_close) begin
                        r_hi    <= r_hi - r_cs;
                        r_q5    <= prod[61:sbal_pkg::RECIP5_SH];
                        r_state <= S_CGROW;
                    end else begin
                        r_state <= S_SNAP;
                    end
                end
                S_CGROW: begin
                    r_cs    <= sbal_pkg::grow_sat(r_cs, r_q5);
                    r_state <= S_SNAP;
                end
                S_SNAP: begin
                    if (r_lo > 32'(r_peak)) begin
                        r_lo <= 32'(r_peak);
                        r_fs <= 32'(i_cfg.decay_start);
                    end
                    if (r_hi < 32'(r_peak)) begin
                        r_hi <= 32'(r_peak);
                        r_cs <= 32'(i_cfg.decay_start);
                    end
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    if (span_ok) begin
                        r_state <= S_DIV;
                    end else begin
                        r_lvl   <= '0;
                        r_state <= S_FALL;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_lvl   <= div_q;
                        r_state <= S_FALL;
                    end
                end
                S_FALL: begin
                    r_result.strobe <= 1'b1;
                    r_result.band   <= r_band;
                    r_result.level  <= scaled[FRACTION_BITS +: sbal_pkg::LEVEL_W];
                    r_result.last   <= (r_band == sbal_pkg::LAST_BAND);
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result = r_result;

    // After the snap the peak lies inside the tracked span.
    a_peak_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN) |-> (r_lo <= 32'(r_peak) && r_hi >= 32'(r_peak)))
        else $error("peak outside tracked span");

endmodule
`default_nettype wire

// ----- rtl/spectrum_band_autorange_levels.sv -----
`default_nettype none
// ============================================================================
// spectrum_band_autorange_levels - six-band peak meter with autorange levels
// Collects per-band peaks of FFT magnitude bins and, at frame end, turns
// them into six slope-limited 0..255 levels against tracked floor/ceiling.
// ============================================================================
// An item is one FFT bin, accepted on a clock edge with start high and busy
// low. For an ordinary bin the band's peak is read from the peak memory and
// written back on the next cycle; busy stays high until the write-back, so
// a new item is not taken before the last one is written back. A bin with
// frame_end set keeps busy high while the six bands are settled one after
// another. A band whose span is too narrow to scale skips the one bit a
// cycle divider. The settle sequencer reads, closes, snaps and writes back
// each band; its two step-growth states are only taken when a tracker
// closes. Each band result appears on o_result_strobe for exactly one
// cycle, band 0 first, with o_last_band on the sixth; the receiver cannot
// hold results off and must take each one as it comes. The configuration
// port is always ready and should only be written while busy is low. No
// clearing pass is needed after reset: both memories carry a valid bit per
// band, and an entry not yet written reads as its reset value.
module spectrum_band_autorange_levels #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_bin_index,
    input  logic [30:0] i_magnitude,
    input  logic        i_frame_end,
    output logic        o_result_strobe,
    output logic [2:0]  o_band_number,
    output logic [7:0]  o_band_level,
    output logic        o_last_band,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE, T_BIN, T_FREAD, T_FSTART, T_FWAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [sbal_pkg::BAND_W-1:0] r_band;
    logic [sbal_pkg::BAND_W-1:0] n_band;

    // Latched item fields.
    logic                        r_bin_hit;
    logic [sbal_pkg::BAND_W-1:0] r_bin_band;
    logic [sbal_pkg::PEAK_W-1:0] r_mag;
    logic                        r_frame;

    sbal_pkg::t_cfg r_cfg;

    // Peak memory, one word per band, with a valid bit per band so that the
    // peaks of a whole frame are cleared at once.
    logic [sbal_pkg::PEAK_W-1:0]     r_peak_mem [sbal_pkg::BAND_COUNT];
    logic [sbal_pkg::BAND_COUNT-1:0] r_peak_vld;
    logic [sbal_pkg::PEAK_W-1:0]     r_peak_rd;
    logic                            r_peak_rd_vld;

    logic [sbal_pkg::BAND_W:0]   lookup;
    logic [sbal_pkg::BAND_W-1:0] peak_rd_addr;
    logic                        peak_wr_en;
    logic                        peak_clear;
    logic [sbal_pkg::PEAK_W-1:0] peak_eff;
    logic                        accept;

    sbal_pkg::t_settle_req settle_req;
    sbal_pkg::t_result     settle_res;

    assign busy        = (r_state != T_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign lookup      = sbal_pkg::band_of(i_bin_index);
    assign peak_eff    = r_peak_rd_vld ? r_peak_rd : '0;

    always_comb begin
        n_state      = r_state;
        n_band       = r_band;
        peak_rd_addr = r_band;
        peak_wr_en   = 1'b0;
        peak_clear   = 1'b0;
        settle_req   = '{start: 1'b0, band: r_band, peak: peak_eff};
        unique case (r_state)
            T_IDLE: begin
                // Read the band of the offered bin ahead of acceptance.
                peak_rd_addr = lookup[sbal_pkg::BAND_W-1:0];
                if (start) begin
                    n_state = T_BIN;
                end
            end
            T_BIN: begin
                peak_wr_en = r_bin_hit && (r_mag > peak_eff);
                if (r_frame) begin
                    n_band  = '0;
                    n_state = T_FREAD;
                end else begin
                    n_state = T_IDLE;
                end
            end
            T_FREAD: begin
                n_state = T_FSTART;
            end
            T_FSTART: begin
                settle_req.start = 1'b1;
                n_state          = T_FWAIT;
            end
            T_FWAIT: begin
                if (settle_res.strobe) begin
                    if (r_band == sbal_pkg::LAST_BAND) begin
                        peak_clear = 1'b1;
                        n_state    = T_IDLE;
                    end else begin
                        n_band  = r_band + 3'd1;
                        n_state = T_FREAD;
                    end
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_band  <= '0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
            if (accept) begin
                r_bin_hit  <= lookup[sbal_pkg::BAND_W];
                r_bin_band <= lookup[sbal_pkg::BAND_W-1:0];
                r_mag      <= i_magnitude;
                r_frame    <= i_frame_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak_rd <= r_peak_mem[peak_rd_addr];
        if (peak_wr_en) begin
            r_peak_mem[r_bin_band] <= r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_vld    <= '0;
            r_peak_rd_vld <= 1'b0;
        end else begin
            r_peak_rd_vld <= r_peak_vld[peak_rd_addr];
            if (peak_clear) begin
                r_peak_vld <= '0;
            end else if (peak_wr_en) begin
                r_peak_vld[r_bin_band] <= 1'b1;
            end
        end
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{decay_start:  sbal_pkg::DECAY_RESET,
                       fall_limit:   sbal_pkg::FALL_RESET,
                       level_cutoff: sbal_pkg::CUT_RESET};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sbal_pkg::t_cfg_index'(i_cfg_index))
                sbal_pkg::CFG_DECAY_START: begin
                    r_cfg.decay_start <= i_cfg_data[sbal_pkg::DS_W-1:0];
                end
                sbal_pkg::CFG_FALL_LIMIT: begin
                    r_cfg.fall_limit <= i_cfg_data;
                end
                sbal_pkg::CFG_LEVEL_CUTOFF: begin
                    r_cfg.level_cutoff <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    sbal_settle #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_settle (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (settle_req),
        .i_cfg    (r_cfg),
        .o_result (settle_res)
    );

    assign o_result_strobe = settle_res.strobe;
    assign o_band_number   = settle_res.band;
    assign o_band_level    = settle_res.level;
    assign o_last_band     = settle_res.last;

    // Results only appear while the frame end is still being worked off.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy)
        else $error("result while idle");

    // The sixth result belongs to the highest band.
    a_last_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last_band) |-> (o_band_number == sbal_pkg::LAST_BAND))
        else $error("last band flag on wrong band");

    // An accepted item always occupies the block for the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted without going busy");

endmodule
`default_nettype wire
